### src/tfct_pkg.sv
package tfct_pkg;

    localparam int NUM_FLOWS_DEF   = 16;
    localparam int MAX_CAPTURE_DEF = 4096;
    localparam int WATCH_PORTS_DEF = 4;

    localparam logic [7:0] PROTO_TCP = 8'd6;

    localparam int PADDR_W = 5;
    localparam logic [2:0] REG_LIMIT  = 3'd0;
    localparam logic [2:0] REG_PORT_A = 3'd1;
    localparam logic [2:0] REG_PORT_B = 3'd2;
    localparam logic [2:0] REG_PORT_C = 3'd3;
    localparam logic [2:0] REG_PORT_D = 3'd4;

    typedef enum logic [2:0] {
        ACT_IGNORED    = 3'd0,
        ACT_OPENED     = 3'd1,
        ACT_DATA       = 3'd2,
        ACT_CLOSED_FIN = 3'd3,
        ACT_CLOSED_RST = 3'd4,
        ACT_CLOSED_LIM = 3'd5,
        ACT_FULL       = 3'd6
    } action_t;

    typedef struct packed {
        logic [7:0]  ip_protocol;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        logic        syn_flag;
        logic        fin_flag;
        logic        rst_flag;
        logic [15:0] ip_total_len;
        logic [5:0]  ip_hdr_len;
        logic [5:0]  tcp_hdr_len;
    } pkt_hdr_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  flow_slot;
        logic [12:0] write_offset;
        logic [12:0] copy_len;
        logic [31:0] packet_count;
        logic [12:0] captured_bytes;
    } flow_result_t;

    // flow key plus counters as stored per table entry
    typedef struct packed {
        logic [95:0] key;
        logic [31:0] packets;
        logic [12:0] bytes;
    } flow_entry_t;

endpackage

### src/tfct_regs.sv
module tfct_regs
    import tfct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [12:0]        limit,
    output logic [15:0]        watch [4]
);

    logic [12:0] limit_reg;
    logic [15:0] watch_reg [4];
    logic [2:0]  idx;
    logic        wr;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign limit  = limit_reg;
    assign watch  = watch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 13'd4096;
            for (int i = 0; i < 4; i++)
                watch_reg[i] <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_LIMIT:  limit_reg    <= pwdata[12:0];
                REG_PORT_A: watch_reg[0] <= pwdata[15:0];
                REG_PORT_B: watch_reg[1] <= pwdata[15:0];
                REG_PORT_C: watch_reg[2] <= pwdata[15:0];
                REG_PORT_D: watch_reg[3] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LIMIT:  prdata = {19'd0, limit_reg};
            REG_PORT_A: prdata = {16'd0, watch_reg[0]};
            REG_PORT_B: prdata = {16'd0, watch_reg[1]};
            REG_PORT_C: prdata = {16'd0, watch_reg[2]};
            REG_PORT_D: prdata = {16'd0, watch_reg[3]};
            default:    prdata = '0;
        endcase
    end

endmodule

### src/tfct_table.sv
module tfct_table
    import tfct_pkg::*;
#(
    parameter int NUM_FLOWS = NUM_FLOWS_DEF,
    localparam int IW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1
)
(
    input  logic          clk,
    input  logic [IW-1:0] rd_idx,
    output flow_entry_t   rd_data,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_idx,
    input  flow_entry_t   wr_data
);

    flow_entry_t mem [NUM_FLOWS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
        rd_data <= mem[rd_idx];
    end

endmodule

### src/tcp_flow_capture_tracker_core.sv
// tcp flow tracker: one packet header per start pulse. busy stays high while
// the header is processed; the result appears for one cycle with done high and
// the receiver cannot stall it. a watched tcp packet scans every table slot
// through the one read port of the flow memory (one slot per cycle, data in the
// next cycle, then the last compare finishes and the block decides). a packet
// that matches an open flow then does one read-modify-write of that entry
// before its result; a packet that opens a flow, finds the table full or misses
// without syn gets its result from the end of the scan, and an ignored packet
// gets its result from the check state without any scan.
// valid bits live in flip-flops cleared at reset, so no clearing pass is needed.
module tcp_flow_capture_tracker_core
    import tfct_pkg::*;
#(
    parameter int NUM_FLOWS   = NUM_FLOWS_DEF,
    parameter int MAX_CAPTURE = MAX_CAPTURE_DEF,
    parameter int WATCH_PORTS = WATCH_PORTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pkt_hdr_t           hdr,
    output logic               done,
    output flow_result_t       result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
    localparam int CW = $clog2(NUM_FLOWS + 1);
    localparam logic [16:0] MAXC = 17'(MAX_CAPTURE);

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_RMW_RD, S_UPDATE} state_t;

    logic [12:0] limit;
    logic [15:0] watch [4];

    tfct_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .limit(limit), .watch(watch)
    );

    state_t        state_reg;
    pkt_hdr_t      hdr_reg;
    logic [NUM_FLOWS-1:0] valid_reg;
    logic [CW-1:0] scan_reg;        // address issued
    logic          cmp_reg;         // read data of slot cmp_idx_reg is present
    logic [IW-1:0] cmp_idx_reg;
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          done_reg;
    logic          done_next;
    flow_result_t  result_reg;

    logic [IW-1:0] rd_idx;
    flow_entry_t   rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    flow_entry_t   wr_data;

    tfct_table #(.NUM_FLOWS(NUM_FLOWS)) u_table (
        .clk(clk), .rd_idx(rd_idx), .rd_data(rd_data),
        .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
    );

    // watched-port match
    logic watched;
    always_comb
    begin
        watched = 1'b0;
        for (int i = 0; i < WATCH_PORTS && i < 4; i++)
            if (watch[i] == hdr_reg.dst_port)
                watched = 1'b1;
        if (hdr_reg.dst_port == 16'd0)
            watched = 1'b0;
    end

    // lowest free slot from the valid bits
    logic          free_ok;
    logic [IW-1:0] free_idx;
    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = NUM_FLOWS - 1; i >= 0; i--)
            if (!valid_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
    end

    logic [95:0] key;
    assign key = {hdr_reg.dst_addr, hdr_reg.src_addr, hdr_reg.dst_port, hdr_reg.src_port};

    // payload and capture arithmetic for the update step
    logic [16:0] lim_eff, hdr_sum, plen, room, take, now_b;
    logic [31:0] pk_new;
    always_comb
    begin
        lim_eff = {4'd0, limit};
        if (lim_eff == 17'd0)
            lim_eff = 17'd1;
        if (lim_eff > MAXC)
            lim_eff = MAXC;
        hdr_sum = 17'(hdr_reg.ip_hdr_len) + 17'(hdr_reg.tcp_hdr_len);
        plen    = ({1'b0, hdr_reg.ip_total_len} > hdr_sum)
                  ? {1'b0, hdr_reg.ip_total_len} - hdr_sum : 17'd0;
        room    = (lim_eff > 17'(rd_data.bytes)) ? lim_eff - 17'(rd_data.bytes) : 17'd0;
        take    = (plen > room) ? room : plen;
        now_b   = 17'(rd_data.bytes) + take;
        pk_new  = rd_data.packets + 32'd1;
    end

    assign rd_idx = (state_reg == S_SCAN) ? scan_reg[IW-1:0] : hit_idx_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = hit_idx_reg;
        wr_data = '{key: key, packets: pk_new, bytes: now_b[12:0]};
        if (state_reg == S_SCAN && scan_reg == CW'(NUM_FLOWS) && !cmp_reg
            && !hit_reg && hdr_reg.syn_flag && free_ok)
        begin
            wr_en   = 1'b1;
            wr_idx  = free_idx;
            wr_data = '{key: key, packets: 32'd1, bytes: 13'd0};
        end
        else if (state_reg == S_UPDATE)
            wr_en = 1'b1;
    end

    // result strobe: ignored packet, end of a scan without a match, or update
    always_comb
    begin
        done_next = 1'b0;
        if (state_reg == S_CHECK && (hdr_reg.ip_protocol != PROTO_TCP || !watched))
            done_next = 1'b1;
        if (state_reg == S_SCAN && scan_reg == CW'(NUM_FLOWS) && !cmp_reg && !hit_reg)
            done_next = 1'b1;
        if (state_reg == S_UPDATE)
            done_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            hdr_reg     <= '0;
            valid_reg   <= '0;
            scan_reg    <= '0;
            cmp_reg     <= 1'b0;
            cmp_idx_reg <= '0;
            hit_reg     <= 1'b0;
            hit_idx_reg <= '0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            done_reg <= done_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        hdr_reg   <= hdr;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (hdr_reg.ip_protocol != PROTO_TCP || !watched)
                    begin
                        result_reg <= '0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        scan_reg  <= '0;
                        cmp_reg   <= 1'b0;
                        hit_reg   <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // compare the entry read last cycle
                    if (cmp_reg && !hit_reg && valid_reg[cmp_idx_reg] && rd_data.key == key)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= cmp_idx_reg;
                    end
                    if (scan_reg != CW'(NUM_FLOWS))
                    begin
                        cmp_reg     <= 1'b1;
                        cmp_idx_reg <= scan_reg[IW-1:0];
                        scan_reg    <= scan_reg + CW'(1);
                    end
                    else if (cmp_reg)
                        cmp_reg <= 1'b0;
                    else if (hit_reg)
                        state_reg <= S_RMW_RD;
                    else
                    begin
                        if (hdr_reg.syn_flag && free_ok)
                        begin
                            valid_reg[free_idx] <= 1'b1;
                            result_reg <= '{action: ACT_OPENED, flow_slot: 4'(free_idx),
                                            write_offset: 13'd0, copy_len: 13'd0,
                                            packet_count: 32'd1, captured_bytes: 13'd0};
                        end
                        else if (hdr_reg.syn_flag)
                            result_reg <= '{action: ACT_FULL, default: '0};
                        else
                            result_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_RMW_RD:
                    state_reg <= S_UPDATE;
                S_UPDATE:
                begin
                    if (hdr_reg.fin_flag || hdr_reg.rst_flag)
                    begin
                        valid_reg[hit_idx_reg] <= 1'b0;
                        result_reg <= '{action: hdr_reg.fin_flag ? ACT_CLOSED_FIN
                                                                 : ACT_CLOSED_RST,
                                        flow_slot: 4'(hit_idx_reg),
                                        write_offset: rd_data.bytes, copy_len: 13'd0,
                                        packet_count: pk_new,
                                        captured_bytes: rd_data.bytes};
                    end
                    else
                    begin
                        if (now_b >= lim_eff)
                            valid_reg[hit_idx_reg] <= 1'b0;
                        result_reg <= '{action: (now_b >= lim_eff) ? ACT_CLOSED_LIM
                                                                   : ACT_DATA,
                                        flow_slot: 4'(hit_idx_reg),
                                        write_offset: rd_data.bytes,
                                        copy_len: take[12:0],
                                        packet_count: pk_new,
                                        captured_bytes: now_b[12:0]};
                    end
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted header not taken");
    a_open_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.action == ACT_OPENED |-> valid_reg[result.flow_slot[IW-1:0]])
        else $error("opened slot not marked valid");
`endif

endmodule

### test/tb_top.sv
module tb_top;
    import tfct_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    pkt_hdr_t           hdr;
    logic               done;
    flow_result_t       result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    tcp_flow_capture_tracker_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .hdr     (hdr),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    localparam int NFLOW = 16;
    localparam int MAXCAP = 4096;
    localparam int HDR_W = $bits(pkt_hdr_t);

    // shadow copy of the registers and of the flow table
    logic [12:0] lim_reg;
    logic [15:0] port_reg [4];
    logic        tbl_valid [NFLOW];
    logic [95:0] tbl_key [NFLOW];
    logic [31:0] tbl_pkts [NFLOW];
    logic [12:0] tbl_bytes [NFLOW];

    flow_result_t pending_results[$];
    int errors;
    int n_sent;
    int n_checked;
    int act_seen [7];

    // small pools of tuples so random traffic hits existing flows
    logic [31:0] pool_daddr [4];
    logic [31:0] pool_saddr [4];
    logic [15:0] pool_sport [4];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #20000000;
        $display("timeout at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic is_watched(input logic [15:0] p);
        if (p == 16'd0)
            return 1'b0;
        for (int k = 0; k < 4; k++)
            if (port_reg[k] == p)
                return 1'b1;
        return 1'b0;
    endfunction

    // compute the tracker's answer for one header and update the shadow table
    function automatic flow_result_t track_packet(input pkt_hdr_t h);
        flow_result_t r;
        logic [95:0]  k;
        int           hit;
        int           free_idx;
        int           eff;
        int           hdrs;
        int           plen;
        int           room;
        int           take;
        int           old;
        r = '0;
        k = {h.dst_addr, h.src_addr, h.dst_port, h.src_port};
        hit = -1;
        free_idx = -1;
        if (h.ip_protocol != PROTO_TCP || !is_watched(h.dst_port))
        begin
            r.action = ACT_IGNORED;
            return r;
        end
        for (int i = 0; i < NFLOW; i++)
        begin
            if (tbl_valid[i])
            begin
                if (hit < 0 && tbl_key[i] == k)
                    hit = i;
            end
            else if (free_idx < 0)
                free_idx = i;
        end
        if (hit < 0)
        begin
            if (!h.syn_flag)
                r.action = ACT_IGNORED;
            else if (free_idx < 0)
                r.action = ACT_FULL;
            else
            begin
                tbl_valid[free_idx] = 1'b1;
                tbl_key[free_idx] = k;
                tbl_pkts[free_idx] = 32'd1;
                tbl_bytes[free_idx] = '0;
                r.action = ACT_OPENED;
                r.flow_slot = free_idx[3:0];
                r.packet_count = 32'd1;
            end
            return r;
        end
        tbl_pkts[hit] = tbl_pkts[hit] + 32'd1;
        old = tbl_bytes[hit];
        r.flow_slot = hit[3:0];
        r.packet_count = tbl_pkts[hit];
        r.write_offset = old[12:0];
        r.captured_bytes = old[12:0];
        if (h.fin_flag || h.rst_flag)
        begin
            // fin wins when both are set
            tbl_valid[hit] = 1'b0;
            r.action = h.fin_flag ? ACT_CLOSED_FIN : ACT_CLOSED_RST;
            return r;
        end
        eff = (lim_reg == 0) ? 1 : ((lim_reg > MAXCAP) ? MAXCAP : int'(lim_reg));
        hdrs = int'(h.ip_hdr_len) + int'(h.tcp_hdr_len);
        plen = (int'(h.ip_total_len) > hdrs) ? int'(h.ip_total_len) - hdrs : 0;
        room = (eff > old) ? eff - old : 0;
        take = (plen > room) ? room : plen;
        tbl_bytes[hit] = 13'(old + take);
        r.copy_len = take[12:0];
        r.captured_bytes = 13'(old + take);
        if (old + take >= eff)
        begin
            tbl_valid[hit] = 1'b0;
            r.action = ACT_CLOSED_LIM;
        end
        else
            r.action = ACT_DATA;
        return r;
    endfunction

    // result monitor: sample on the rising edge, compare with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transfer %h", $time, result);
                errors++;
            end
            else
            begin
                flow_result_t e;
                e = pending_results.pop_front();
                n_checked++;
                act_seen[e.action]++;
                if (result.action !== e.action)
                begin
                    $display("%0t: action exp %0d got %0d", $time, e.action, result.action);
                    errors++;
                end
                if (result.flow_slot !== e.flow_slot)
                begin
                    $display("%0t: flow_slot exp %0d got %0d", $time, e.flow_slot,
                             result.flow_slot);
                    errors++;
                end
                if (result.write_offset !== e.write_offset)
                begin
                    $display("%0t: write_offset exp %0d got %0d", $time, e.write_offset,
                             result.write_offset);
                    errors++;
                end
                if (result.copy_len !== e.copy_len)
                begin
                    $display("%0t: copy_len exp %0d got %0d", $time, e.copy_len,
                             result.copy_len);
                    errors++;
                end
                if (result.packet_count !== e.packet_count)
                begin
                    $display("%0t: packet_count exp %0d got %0d", $time, e.packet_count,
                             result.packet_count);
                    errors++;
                end
                if (result.captured_bytes !== e.captured_bytes)
                begin
                    $display("%0t: captured_bytes exp %0d got %0d", $time,
                             e.captured_bytes, result.captured_bytes);
                    errors++;
                end
            end
        end
    end

    // apb write plus read-back; the shadow registers follow
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = PADDR_W'({idx, 2'b00});
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (idx == REG_LIMIT)
            lim_reg = val[12:0];
        else
            port_reg[idx - 1] = val[15:0];
        if (prdata !== ((idx == REG_LIMIT) ? {19'd0, val[12:0]} : {16'd0, val[15:0]}))
        begin
            $display("%0t: reg %0d read exp %h got %h", $time, idx, val, prdata);
            errors++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // block is idle: nothing waiting, plus room for a packet still in flight
    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    // one header transfer with a random lead-in gap
    task automatic send_packet(input pkt_hdr_t h, input bit idle_ok);
        int gap;
        gap = idle_ok ? $urandom_range(0, 16) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) @(negedge clk);
        start = 1'b1;
        hdr = h;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(track_packet(h));
        n_sent++;
        @(negedge clk);
        start = 1'b0;
        hdr = pkt_hdr_t'(HDR_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    endtask

    function automatic pkt_hdr_t make_tcp(input logic [15:0] dport, input int tup,
                                          input logic s, input logic f, input logic r,
                                          input logic [15:0] tot);
        pkt_hdr_t h;
        h.ip_protocol = PROTO_TCP;
        h.dst_port = dport;
        h.src_port = pool_sport[tup];
        h.dst_addr = pool_daddr[tup];
        h.src_addr = pool_saddr[tup];
        h.syn_flag = s;
        h.fin_flag = f;
        h.rst_flag = r;
        h.ip_total_len = tot;
        h.ip_hdr_len = 6'd20;
        h.tcp_hdr_len = 6'd20;
        return h;
    endfunction

    // directed table: header, check flag, hand-typed expectation
    typedef struct {
        pkt_hdr_t     h;
        bit           typed;
        flow_result_t r;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic flow_result_t res(input action_t a, input int s, input int o,
                                         input int l, input int p, input int b);
        flow_result_t r;
        r.action = a;
        r.flow_slot = s[3:0];
        r.write_offset = o[12:0];
        r.copy_len = l[12:0];
        r.packet_count = p;
        r.captured_bytes = b[12:0];
        return r;
    endfunction

    initial
    begin
        pkt_hdr_t h;
        int phase;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        foreach (act_seen[i])
            act_seen[i] = 0;
        rst_n = 1'b0;
        start = 1'b0;
        hdr = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        lim_reg = 13'd4096;
        foreach (port_reg[i])
            port_reg[i] = '0;
        foreach (tbl_valid[i])
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_pkts[i] = '0;
            tbl_bytes[i] = '0;
        end
        for (int i = 0; i < 4; i++)
        begin
            pool_daddr[i] = $urandom;
            pool_saddr[i] = $urandom;
            pool_sport[i] = 16'($urandom);
        end
        pool_daddr[0] = 32'hFFFF_FFFF;
        pool_saddr[0] = 32'h0;
        pool_sport[0] = 16'hFFFF;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part: nothing is watched after reset, so a syn is ignored
        dir_rows.push_back('{make_tcp(16'd80, 0, 1, 0, 0, 16'd100), 1,
                             res(ACT_IGNORED, 0, 0, 0, 0, 0)});
        for (int i = 0; i < dir_rows.size(); i++)
        begin
            send_packet(dir_rows[i].h, 1'b0);
            if (dir_rows[i].typed)
                pending_results[pending_results.size() - 1] = dir_rows[i].r;
        end
        drain();
        dir_rows.delete();
        write_reg(REG_PORT_A, 32'hFFFF);
        write_reg(REG_PORT_B, 32'd80);
        write_reg(REG_PORT_C, 32'd0);
        write_reg(REG_PORT_D, 32'd1);
        write_reg(REG_LIMIT, 32'd100);
        h = make_tcp(16'd80, 0, 1, 0, 0, 16'd0);
        h.ip_protocol = 8'd17;
        dir_rows.push_back('{h, 1, res(ACT_IGNORED, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{make_tcp(16'd0, 0, 1, 0, 0, 16'd0), 1,
                             res(ACT_IGNORED, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{make_tcp(16'hFFFF, 0, 0, 0, 0, 16'd500), 1,
                             res(ACT_IGNORED, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{make_tcp(16'hFFFF, 0, 1, 0, 0, 16'd0), 1,
                             res(ACT_OPENED, 0, 0, 0, 1, 0)});
        // header lengths bigger than total: payload clamps to zero
        dir_rows.push_back('{make_tcp(16'hFFFF, 0, 0, 0, 0, 16'd10), 1,
                             res(ACT_DATA, 0, 0, 0, 2, 0)});
        dir_rows.push_back('{make_tcp(16'hFFFF, 0, 0, 0, 0, 16'd90), 0, '0});
        dir_rows.push_back('{make_tcp(16'hFFFF, 0, 0, 0, 0, 16'hFFFF), 0, '0});
        dir_rows.push_back('{make_tcp(16'd80, 1, 1, 0, 0, 16'd0), 0, '0});
        dir_rows.push_back('{make_tcp(16'd80, 1, 0, 1, 1, 16'd0), 0, '0});
        dir_rows.push_back('{make_tcp(16'd1, 2, 1, 0, 0, 16'd0), 0, '0});
        dir_rows.push_back('{make_tcp(16'd1, 2, 1, 0, 1, 16'd70), 0, '0});
        for (int i = 0; i < dir_rows.size(); i++)
        begin
            send_packet(dir_rows[i].h, 1'b1);
            if (dir_rows[i].typed)
                pending_results[pending_results.size() - 1] = dir_rows[i].r;
        end
        // fill the table, then one more syn finds it full
        for (int i = 0; i < NFLOW + 1; i++)
        begin
            h = make_tcp(16'd80, 3, 1, 0, 0, 16'd0);
            h.src_port = 16'(i + 1000);
            send_packet(h, 1'b0);
        end
        // sender holds off until every result is back
        drain();

        // random phases across limit settings, extremes included
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_reg(REG_LIMIT, 32'd0);
                1: write_reg(REG_LIMIT, 32'd4096);
                2: write_reg(REG_LIMIT, 32'h1FFF);
                3: write_reg(REG_LIMIT, 32'd1);
                default: write_reg(REG_LIMIT, $urandom_range(1, 400));
            endcase
            write_reg(REG_PORT_C, $urandom);
            for (int n = 0; n < 135; n++)
            begin
                int sel;
                int tup;
                logic [15:0] dp;
                sel = $urandom_range(0, 99);
                tup = $urandom_range(0, 3);
                dp = port_reg[$urandom_range(0, 3)];
                h = make_tcp(dp, tup, $urandom_range(0, 4) == 0,
                             $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                             16'($urandom_range(0, 400)));
                h.ip_hdr_len = 6'($urandom_range(0, 60));
                h.tcp_hdr_len = 6'($urandom_range(0, 60));
                if (sel < 5)
                    h.ip_total_len = 16'($urandom);
                if (sel < 12)
                    h = pkt_hdr_t'(HDR_W'({$urandom, $urandom, $urandom, $urandom,
                                           $urandom}));
                else if (sel < 20)
                    h.src_port = 16'($urandom);
                send_packet(h, phase != 2);
            end
            drain();
        end

        $display("checked %0d of %0d transfers: opened %0d data %0d fin %0d rst %0d",
                 n_checked, n_sent, act_seen[1], act_seen[2], act_seen[3], act_seen[4]);
        $display("limit closes %0d, table full %0d, ignored %0d",
                 act_seen[5], act_seen[6], act_seen[0]);
        if (errors == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### files.f
src/tfct_pkg.sv
src/tfct_regs.sv
src/tfct_table.sv
src/tcp_flow_capture_tracker_core.sv
test/tb_top.sv
